// ===== rtl/fdf_pkg.sv =====
`default_nettype none

package fdf_pkg;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_PUSH = 2'd1,
    KIND_POP  = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic        has_value;
    logic [31:0] value_out;
    logic        dropped;
    logic [4:0]  occupancy;
    logic [4:0]  waiting;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/fdf_ram.sv =====
`default_nettype none

module fdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read of the entry being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/fixed_delay_fifo_unit.sv =====
// A result word is decided in the EXEC state once the result register is free, then registered.
// The block takes one input word at a time: accepting a word reads the head entry
// from the value and reveal memories, and the EXEC state then decides the release.
// A stalled output holds the EXEC state until the result register drains.
// Reset (rst_ni low, asynchronous) clears pointers, counters, tick time and delay;
// the memories are not cleared and only occupied entries are ever released.
`default_nettype none

module fixed_delay_fifo_unit #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire fdf_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output fdf_pkg::out_t     out_data_o,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_q, state_d;
  logic [PtrW-1:0]       head_q, head_d;
  logic [PtrW-1:0]       tail_q, tail_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       pend_q, pend_d;
  logic [31:0]           now_q, now_d;
  logic [15:0]           delay_q, delay_d;
  logic                  dropped_q, dropped_d;
  logic                  fwd_q, fwd_d;
  logic [VALUE_BITS-1:0] fwd_val_q;
  logic [31:0]           fwd_rev_q;
  logic                  out_valid_q, out_valid_d;
  fdf_pkg::out_t         out_q, out_d;

  logic                  accept;
  logic                  is_full;
  logic                  push_ok;
  logic [63:0]           wide_in;
  logic [VALUE_BITS-1:0] wr_val;
  logic [31:0]           wr_rev;
  logic [VALUE_BITS-1:0] val_rdata;
  logic [31:0]           rev_rdata;
  logic [VALUE_BITS-1:0] head_val;
  logic [31:0]           head_rev;
  logic [31:0]           diff;
  logic                  release_ok;
  logic                  out_free;
  logic [63:0]           head_wide;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(DEPTH));
  assign push_ok    = accept && (in_data_i.kind == fdf_pkg::KIND_PUSH) && !is_full;
  assign wide_in    = {32'd0, in_data_i.value};
  assign wr_val     = wide_in[VALUE_BITS-1:0];
  assign wr_rev     = now_q + 32'(delay_q);

  fdf_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (push_ok),
    .waddr_i(tail_q),
    .wdata_i(wr_val),
    .re_i   (accept),
    .raddr_i(head_q),
    .rdata_o(val_rdata)
  );

  fdf_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_rev_ram (
    .clk_i  (clk_i),
    .we_i   (push_ok),
    .waddr_i(tail_q),
    .wdata_i(wr_rev),
    .re_i   (accept),
    .raddr_i(head_q),
    .rdata_o(rev_rdata)
  );

  // A push into an empty store writes the entry that is read as the head in the
  // same cycle, so the written word bypasses the memory.
  assign head_val   = fwd_q ? fwd_val_q : val_rdata;
  assign head_rev   = fwd_q ? fwd_rev_q : rev_rdata;
  assign diff       = now_q - head_rev;
  assign release_ok = (pend_q != '0) && (count_q != '0) && !diff[31];
  assign out_free   = !out_valid_q || out_ready_i;
  assign head_wide  = 64'(head_val);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    pend_d      = pend_q;
    now_d       = now_q;
    delay_d     = cfg_we_i ? cfg_wdata_i : delay_q;
    dropped_d   = dropped_q;
    fwd_d       = fwd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.kind)
            fdf_pkg::KIND_TICK: begin
              now_d = now_q + 32'd1;
            end
            fdf_pkg::KIND_PUSH: begin
              if (!is_full) begin
                tail_d  = (tail_q == PtrW'(DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
                count_d = count_q + CntW'(1);
              end
            end
            fdf_pkg::KIND_POP: begin
              if (pend_q != CntW'(DEPTH)) begin
                pend_d = pend_q + CntW'(1);
              end
            end
            default: begin
            end
          endcase
          dropped_d = (in_data_i.kind == fdf_pkg::KIND_PUSH) && is_full;
          fwd_d     = push_ok && (tail_q == head_q);
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          if (release_ok) begin
            head_d  = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + PtrW'(1);
            count_d = count_q - CntW'(1);
            pend_d  = pend_q - CntW'(1);
          end
          out_d.has_value = release_ok;
          out_d.value_out = release_ok ? head_wide[31:0] : 32'd0;
          out_d.dropped   = dropped_q;
          out_d.occupancy = 5'(count_d);
          out_d.waiting   = 5'(pend_d);
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      pend_q      <= '0;
      now_q       <= '0;
      delay_q     <= '0;
      dropped_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      now_q       <= now_d;
      delay_q     <= delay_d;
      dropped_q   <= dropped_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (push_ok) begin
      fwd_val_q <= wr_val;
      fwd_rev_q <= wr_rev;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/fdf_checker.sv =====
`default_nettype none

module fdf_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire fdf_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire fdf_pkg::out_t out_data_o,
  input wire logic          cfg_we_i,
  input wire logic [15:0]   cfg_wdata_i
);

  // A stalled result word holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // A result word released without a value flag carries a zero data field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_value |-> out_data_o.value_out == 32'd0)
    else $error("value_out nonzero without has_value");

  // One word is processed at a time: no input is taken right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous word still in work");

  // With the result register free at accept, the result passes through EXEC into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (!out_valid_o || out_ready_i) |-> ##2 out_valid_o)
    else $error("result word did not appear two cycles after accept");

endmodule

bind fixed_delay_fifo_unit fdf_checker u_fdf_checker (.*);

`default_nettype wire

// ===== verif/fixed_delay_fifo_unit_tb.sv =====
`timescale 1ns / 1ps

module fixed_delay_fifo_unit_tb;

  localparam int DEPTH_N     = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLDOFF_LEN = 300;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  fdf_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  fdf_pkg::out_t out_data_o;
  logic          cfg_we_i    = 1'b0;
  logic [15:0]   cfg_wdata_i = '0;

  fixed_delay_fifo_unit #(
    .DEPTH      (DEPTH_N),
    .VALUE_BITS (32)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the queue state, advanced once per accepted input word.
  logic [31:0] shadow_value  [DEPTH_N];
  logic [31:0] shadow_reveal [DEPTH_N];
  logic [3:0]  shadow_head;
  logic [3:0]  shadow_tail;
  logic [4:0]  shadow_count;
  logic [31:0] shadow_now;
  logic [4:0]  shadow_pops;
  logic [15:0] shadow_delay;

  fdf_pkg::out_t result_due_q[$];
  int   mismatches     = 0;
  int   cycle_count    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  bit   holdoff_req    = 1'b0;
  int   holdoff_left   = 0;

  function automatic void clear_shadow();
    for (int i = 0; i < DEPTH_N; i++) begin
      shadow_value[i]  = '0;
      shadow_reveal[i] = '0;
    end
    shadow_head  = '0;
    shadow_tail  = '0;
    shadow_count = '0;
    shadow_now   = '0;
    shadow_pops  = '0;
    shadow_delay = '0;
  endfunction

  function automatic fdf_pkg::out_t delayed_release(input fdf_pkg::in_t w);
    fdf_pkg::out_t r;
    logic [31:0]   age;
    r = '0;
    case (w.kind)
      fdf_pkg::KIND_TICK: shadow_now = shadow_now + 32'd1;
      fdf_pkg::KIND_PUSH: begin
        if (shadow_count >= DEPTH_N) begin
          r.dropped = 1'b1;
        end else begin
          shadow_value[shadow_tail]  = w.value;
          shadow_reveal[shadow_tail] = shadow_now + {16'h0, shadow_delay};
          shadow_tail  = shadow_tail + 4'd1;
          shadow_count = shadow_count + 5'd1;
        end
      end
      fdf_pkg::KIND_POP: begin
        if (shadow_pops < DEPTH_N) shadow_pops = shadow_pops + 5'd1;
      end
      default: ;
    endcase
    // Maturity is judged on the sign of the difference so that time may wrap.
    age = shadow_now - shadow_reveal[shadow_head];
    if (shadow_pops != 0 && shadow_count != 0 && !age[31]) begin
      r.has_value  = 1'b1;
      r.value_out  = shadow_value[shadow_head];
      shadow_head  = shadow_head + 4'd1;
      shadow_count = shadow_count - 5'd1;
      shadow_pops  = shadow_pops - 5'd1;
    end
    r.occupancy = shadow_count;
    r.waiting   = shadow_pops;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL fixed_delay_fifo_unit");
      $finish;
    end
  end

  // The receiver normally stalls at random; a requested hold-off keeps it
  // stalled for a long stretch so the block backs up into its input.
  always @(posedge clk_i) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_LEN;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left > 0) begin
      out_ready_i <= 1'b0;
      holdoff_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    fdf_pkg::out_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_data_o);
      end else begin
        exp = result_due_q.pop_front();
        if (out_data_o.has_value !== exp.has_value ||
            out_data_o.value_out !== exp.value_out ||
            out_data_o.dropped !== exp.dropped ||
            out_data_o.occupancy !== exp.occupancy ||
            out_data_o.waiting !== exp.waiting) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected has=%0d val=%h drop=%0d occ=%0d wait=%0d,",
                      " got has=%0d val=%h drop=%0d occ=%0d wait=%0d"},
                     exp.has_value, exp.value_out, exp.dropped, exp.occupancy,
                     exp.waiting, out_data_o.has_value, out_data_o.value_out,
                     out_data_o.dropped, out_data_o.occupancy, out_data_o.waiting);
        end
      end
    end
  end

  task automatic send_word(input fdf_pkg::in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    result_due_q.push_back(delayed_release(w));
  endtask

  task automatic send_kind(input fdf_pkg::kind_e k, input logic [31:0] v);
    fdf_pkg::in_t w;
    w.kind  = k;
    w.value = v;
    send_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_delay(input logic [15:0] d);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    shadow_delay = d;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(input int n, input int push_w, input int pop_w);
    fdf_pkg::in_t w;
    int           r;
    for (int i = 0; i < n; i++) begin
      r       = $urandom_range(99);
      w.value = $urandom;
      if (r < 3) w.kind = fdf_pkg::KIND_NOP;
      else if (r < 3 + push_w) w.kind = fdf_pkg::KIND_PUSH;
      else if (r < 3 + push_w + pop_w) w.kind = fdf_pkg::KIND_POP;
      else w.kind = fdf_pkg::KIND_TICK;
      send_word(w);
    end
  endtask

  // Zero delay: waiting pops and pushes meet within the same word.
  task automatic test_zero_delay();
    send_kind(fdf_pkg::KIND_POP,  32'h1234_5678);
    send_kind(fdf_pkg::KIND_POP,  32'h0);
    send_kind(fdf_pkg::KIND_PUSH, 32'h0000_0000);
    send_kind(fdf_pkg::KIND_PUSH, 32'hFFFF_FFFF);
    send_kind(fdf_pkg::KIND_PUSH, 32'hA5A5_A5A5);
    send_kind(fdf_pkg::KIND_NOP,  32'hFFFF_FFFF);
    send_kind(fdf_pkg::KIND_TICK, 32'h5A5A_5A5A);
    send_kind(fdf_pkg::KIND_POP,  32'h0);
    send_kind(fdf_pkg::KIND_NOP,  32'h0);
    drain();
  endtask

  // A pop waits for the head to mature; a late pop on a mature head is immediate.
  task automatic test_short_delay();
    write_delay(16'd3);
    send_kind(fdf_pkg::KIND_PUSH, 32'hDEAD_BEEF);
    send_kind(fdf_pkg::KIND_POP,  32'h0);
    send_kind(fdf_pkg::KIND_TICK, 32'h0);
    send_kind(fdf_pkg::KIND_TICK, 32'h0);
    send_kind(fdf_pkg::KIND_NOP,  32'h0);
    send_kind(fdf_pkg::KIND_TICK, 32'h0);
    send_kind(fdf_pkg::KIND_PUSH, 32'h8000_0001);
    send_kind(fdf_pkg::KIND_TICK, 32'h0);
    send_kind(fdf_pkg::KIND_TICK, 32'h0);
    send_kind(fdf_pkg::KIND_TICK, 32'h0);
    send_kind(fdf_pkg::KIND_POP,  32'h0);
    drain();
  endtask

  task automatic test_random_phases();
    int delays [8] = '{0, 1, 4, 9, 0, 2, 16, 7};
    for (int p = 0; p < 8; p++) begin
      write_delay(16'(delays[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      // Balanced, push-heavy (fills the store) and pop-heavy (saturates waiting).
      case (p % 3)
        0: send_random(175, 35, 35);
        1: send_random(175, 55, 22);
        default: send_random(175, 22, 55);
      endcase
    end
    drain();
  endtask

  task automatic test_output_holdoff();
    write_delay(16'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    holdoff_req = 1'b1;
    send_random(80, 45, 45);
    drain();
  endtask

  // The largest delay goes last: its entries never mature within the run,
  // so pops pile up to the limit and pushes fill the store.
  task automatic test_max_delay();
    write_delay(16'hFFFF);
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    send_random(60, 45, 45);
    drain();
  endtask

  initial begin
    clear_shadow();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_delay();
    test_short_delay();
    test_random_phases();
    test_output_holdoff();
    test_max_delay();
    repeat (10) @(posedge clk_i);
    mismatches += result_due_q.size();
    if (mismatches == 0) begin
      $display("PASS fixed_delay_fifo_unit");
    end else begin
      $display("FAIL fixed_delay_fifo_unit");
    end
    $finish;
  end

endmodule
